FILE: rtl/aid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aid_pkg
// Shared codes, flag positions and record types of the ARM instruction decoder.
// ----------------------------------------------------------------------------
package aid_pkg;

  localparam int WordW  = 32;
  localparam int ClassW = 4;
  localparam int FlagW  = 11;
  localparam int OutW   = 80;

  localparam logic [ClassW-1:0] CLS_UNDEC = 4'd0;
  localparam logic [ClassW-1:0] CLS_DP    = 4'd1;
  localparam logic [ClassW-1:0] CLS_MUL   = 4'd2;
  localparam logic [ClassW-1:0] CLS_MULL  = 4'd3;
  localparam logic [ClassW-1:0] CLS_SDT   = 4'd4;
  localparam logic [ClassW-1:0] CLS_HW    = 4'd5;
  localparam logic [ClassW-1:0] CLS_BDT   = 4'd6;
  localparam logic [ClassW-1:0] CLS_SWP   = 4'd7;
  localparam logic [ClassW-1:0] CLS_B     = 4'd8;
  localparam logic [ClassW-1:0] CLS_BX    = 4'd9;
  localparam logic [ClassW-1:0] CLS_SWI   = 4'd10;

  localparam int F_IMM  = 0;
  localparam int F_SETF = 1;
  localparam int F_ACC  = 2;
  localparam int F_SIGN = 3;
  localparam int F_PRE  = 4;
  localparam int F_UP   = 5;
  localparam int F_BYTE = 6;
  localparam int F_WB   = 7;
  localparam int F_LOAD = 8;
  localparam int F_PSRL = 9;
  localparam int F_SREG = 10;

  localparam logic [21:0] BX_PATTERN = 22'b0100101111111111110001;

  typedef struct packed {
    logic [WordW-1:0]  word;
    logic [ClassW-1:0] cls;
  } cls_item_t;

  typedef struct packed {
    logic [FlagW-1:0]  flags;
    logic [WordW-1:0]  imm;
    logic [4:0]        samt;
    logic [1:0]        stype;
    logic [3:0]        rm;
    logic [3:0]        rs;
    logic [3:0]        rn;
    logic [3:0]        rd;
    logic [3:0]        alu;
    logic [ClassW-1:0] cls;
    logic [3:0]        cond;
  } dec_t;

endpackage
`default_nettype wire

FILE: rtl/arm32_instruction_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arm32_instruction_decoder_core
// ARM-state instruction decoder with a three-stage elastic pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one 32-bit instruction word per item on in_tdata.
//   Output channel out_*: one decoded record per item on out_tdata.
//   From input acceptance to out_tvalid an item passes an input register,
//   a class decode register and a field extraction register. Throughput
//   is one item per cycle while out_tready is high; each stage takes a
//   new item whenever it is empty or its content moves on in the same cycle.
//   When the receiver stalls, items pile up in the three stages and
//   in_tready falls only once all of them are full; nothing is dropped
//   or repeated.
//   Reset clears the stage valid bits; the block is ready again in the
//   first cycle after reset is released.
// ----------------------------------------------------------------------------
module arm32_instruction_decoder_core
  import aid_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // [31:0] instruction_word
  input  wire logic [WordW-1:0] in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // [3:0] condition, [7:4] class_code, [11:8] alu_opcode, [15:12] dest_reg,
  // [19:16] base_reg, [23:20] shift_reg, [27:24] source_reg,
  // [29:28] shift_type, [34:30] shift_amount, [66:35] immediate,
  // [77:67] control_flags, [79:78] zero
  output logic [OutW-1:0]       out_tdata
);

  logic             s1_valid_r;
  logic [WordW-1:0] s1_word_r;
  logic             s2_ready;
  logic             s2_valid;
  cls_item_t        s2_item;
  logic             s3_ready;
  dec_t             rec;

  assign in_tready = !s1_valid_r || s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_word_r <= in_tdata;
    end
  end

  aid_classify u_classify (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid_r),
    .ready_o (s2_ready),
    .word_i  (s1_word_r),
    .valid_o (s2_valid),
    .ready_i (s3_ready),
    .item_o  (s2_item)
  );

  aid_extract u_extract (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s2_valid),
    .ready_o (s3_ready),
    .item_i  (s2_item),
    .valid_o (out_tvalid),
    .ready_i (out_tready),
    .rec_o   (rec)
  );

  assign out_tdata = {2'b00, rec.flags, rec.imm, rec.samt, rec.stype, rec.rm, rec.rs,
                      rec.rn, rec.rd, rec.alu, rec.cls, rec.cond};

endmodule
`default_nettype wire

FILE: rtl/aid_classify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aid_classify
// Class decode stage: finds the instruction class in priority order.
// ----------------------------------------------------------------------------
module aid_classify
  import aid_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [WordW-1:0] word_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output cls_item_t             item_o
);

  logic              valid_r;
  cls_item_t         item_r;
  logic [ClassW-1:0] cls_nxt;
  logic              mul_form;
  logic              hw_form;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign item_o  = item_r;

  assign mul_form = word_i[7:4] == 4'b1001;
  assign hw_form  = !word_i[25] && word_i[7] && word_i[4];

  always_comb begin
    cls_nxt = CLS_UNDEC;
    case (word_i[27:26])
      2'b00: begin
        if (mul_form && word_i[27:23] == 5'b00000) begin
          cls_nxt = CLS_MUL;
        end else if (mul_form && word_i[27:23] == 5'b00001) begin
          cls_nxt = CLS_MULL;
        end else if (mul_form && word_i[27:23] == 5'b00010 && word_i[11:8] == 4'b0000) begin
          cls_nxt = CLS_SWP;
        end else if (word_i[7:4] == 4'b0001 && word_i[25:4] == BX_PATTERN) begin
          cls_nxt = CLS_BX;
        end else if (hw_form) begin
          if (!word_i[22] && word_i[11:8] != 4'b0000) begin
            cls_nxt = CLS_UNDEC;
          end else begin
            cls_nxt = CLS_HW;
          end
        end else begin
          cls_nxt = CLS_DP;
        end
      end
      2'b01: begin
        cls_nxt = CLS_SDT;
      end
      2'b10: begin
        cls_nxt = word_i[25] ? CLS_B : CLS_BDT;
      end
      default: begin
        cls_nxt = (word_i[25:24] == 2'b11) ? CLS_SWI : CLS_UNDEC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      item_r.word <= word_i;
      item_r.cls  <= cls_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/aid_extract.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aid_extract
// Field extraction stage: builds the decoded record from word and class.
// ----------------------------------------------------------------------------
module aid_extract
  import aid_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      valid_i,
  output logic           ready_o,
  input  wire cls_item_t item_i,
  output logic           valid_o,
  input  wire logic      ready_i,
  output dec_t           rec_o
);

  logic             valid_r;
  dec_t             rec_r;
  dec_t             rec_nxt;
  logic [WordW-1:0] w;
  logic [4:0]       rot;
  logic [63:0]      rot_pair;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign rec_o   = rec_r;

  assign w        = item_i.word;
  assign rot      = {w[11:8], 1'b0};
  assign rot_pair = {24'd0, w[7:0], 24'd0, w[7:0]} >> rot;

  always_comb begin
    rec_nxt      = '0;
    rec_nxt.cond = w[31:28];
    rec_nxt.cls  = item_i.cls;
    case (item_i.cls)
      CLS_DP: begin
        rec_nxt.alu          = w[24:21];
        rec_nxt.rn           = w[19:16];
        rec_nxt.rd           = w[15:12];
        rec_nxt.flags[F_IMM]  = w[25];
        rec_nxt.flags[F_SETF] = w[20];
        if (w[25]) begin
          rec_nxt.imm = rot_pair[WordW-1:0];
        end else begin
          rec_nxt.rm    = w[3:0];
          rec_nxt.stype = w[6:5];
          if (w[4]) begin
            rec_nxt.rs           = w[11:8];
            rec_nxt.flags[F_SREG] = 1'b1;
          end else begin
            rec_nxt.samt = w[11:7];
          end
        end
      end
      CLS_MUL, CLS_MULL: begin
        rec_nxt.rd            = w[19:16];
        rec_nxt.rn            = w[15:12];
        rec_nxt.rs            = w[11:8];
        rec_nxt.rm            = w[3:0];
        rec_nxt.flags[F_SETF] = w[20];
        rec_nxt.flags[F_ACC]  = w[21];
        rec_nxt.flags[F_SIGN] = (item_i.cls == CLS_MULL) ? w[22] : 1'b0;
      end
      CLS_SWP: begin
        rec_nxt.rn            = w[19:16];
        rec_nxt.rd            = w[15:12];
        rec_nxt.rm            = w[3:0];
        rec_nxt.flags[F_BYTE] = w[22];
      end
      CLS_BX: begin
        rec_nxt.rm = w[3:0];
      end
      CLS_HW: begin
        rec_nxt.rn            = w[19:16];
        rec_nxt.rd            = w[15:12];
        rec_nxt.stype         = w[6:5];
        rec_nxt.flags[F_IMM]  = w[22];
        rec_nxt.flags[F_PRE]  = w[24];
        rec_nxt.flags[F_UP]   = w[23];
        rec_nxt.flags[F_WB]   = w[21];
        rec_nxt.flags[F_LOAD] = w[20];
        if (w[22]) begin
          rec_nxt.imm = {24'd0, w[11:8], w[3:0]};
        end else begin
          rec_nxt.rm = w[3:0];
        end
      end
      CLS_SDT: begin
        rec_nxt.rn            = w[19:16];
        rec_nxt.rd            = w[15:12];
        rec_nxt.flags[F_IMM]  = !w[25];
        rec_nxt.flags[F_PRE]  = w[24];
        rec_nxt.flags[F_UP]   = w[23];
        rec_nxt.flags[F_BYTE] = w[22];
        rec_nxt.flags[F_WB]   = w[21];
        rec_nxt.flags[F_LOAD] = w[20];
        if (w[25]) begin
          rec_nxt.rm    = w[3:0];
          rec_nxt.stype = w[6:5];
          if (w[4]) begin
            rec_nxt.rs           = w[11:8];
            rec_nxt.flags[F_SREG] = 1'b1;
          end else begin
            rec_nxt.samt = w[11:7];
          end
        end else begin
          rec_nxt.imm = {20'd0, w[11:0]};
        end
      end
      CLS_BDT: begin
        rec_nxt.rn            = w[19:16];
        rec_nxt.imm           = {16'd0, w[15:0]};
        rec_nxt.flags[F_PRE]  = w[24];
        rec_nxt.flags[F_UP]   = w[23];
        rec_nxt.flags[F_PSRL] = w[22];
        rec_nxt.flags[F_WB]   = w[21];
        rec_nxt.flags[F_LOAD] = w[20];
      end
      CLS_B: begin
        rec_nxt.imm           = {{6{w[23]}}, w[23:0], 2'b00};
        rec_nxt.flags[F_PSRL] = w[24];
      end
      default: begin
        rec_nxt.cls = item_i.cls;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      rec_r <= rec_nxt;
    end
  end

  a_undec_clear: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && rec_r.cls == CLS_UNDEC |-> rec_r.flags == '0 && rec_r.imm == '0 &&
      rec_r.rd == '0 && rec_r.rn == '0 && rec_r.rm == '0 && rec_r.rs == '0)
    else $error("undecoded item carries nonzero fields");

  a_alu_dp_only: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && rec_r.cls != CLS_DP |-> rec_r.alu == '0)
    else $error("alu opcode outside data processing");

  a_samt_sreg: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && rec_r.flags[F_SREG] |-> rec_r.samt == '0)
    else $error("shift amount set with register shift");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !ready_i |=> valid_r && $stable(rec_r))
    else $error("stalled record changed");

endmodule
`default_nettype wire
